@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked on every rising clk outside reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ src/hbgt_pkg.sv @@
package hbgt_pkg;

  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 8;
  localparam int KIND_W      = 3;

  localparam logic [KIND_W-1:0] KIND_BLACKLIST = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SELECT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUCCESS   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd4;

  localparam logic [1:0] ST_WHITE      = 2'd0;
  localparam logic [1:0] ST_GRAY_IDLE  = 2'd1;
  localparam logic [1:0] ST_GRAY_PROBE = 2'd2;
  localparam logic [1:0] ST_BLACK      = 2'd3;

  typedef enum logic [2:0] {
    OP_BLACKLIST,
    OP_SELECT,
    OP_SUCCESS,
    OP_CLEAR,
    OP_TICK,
    OP_NONE
  } hbgt_op_t;

  typedef struct packed {
    logic        is_ipv6;
    logic [7:0]  transport_code;
    logic [15:0] port_number;
    logic [63:0] addr_low;
    logic [63:0] addr_high;
  } hbgt_key_t;

  // input word layout, first field highest
  typedef struct packed {
    logic [4:0]  pad;
    logic        allow_black;
    logic        allow_white;
    logic [19:0] gray_ttl;
    logic [19:0] black_ttl;
    hbgt_key_t   key;
  } hbgt_in_word_t;

  typedef struct packed {
    logic [3:0] pad;
    logic       table_full;
    logic       allowed;
    logic [1:0] host_status;
  } hbgt_out_word_t;

  typedef struct packed {
    hbgt_op_t    op;
    hbgt_key_t   key;
    logic [19:0] black_ttl;
    logic [19:0] gray_ttl;
    logic        allow_white;
    logic        allow_black;
  } hbgt_item_t;

  typedef struct packed {
    hbgt_key_t   key;
    logic [31:0] black_expiry;
    logic [31:0] gray_expiry;
    logic        probing_mark;
  } hbgt_entry_t;

  typedef struct packed {
    logic busy;
    logic result_pending;
  } hbgt_back_status_t;

endpackage

@@ src/hbgt_front.sv @@
module hbgt_front import hbgt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,  // addr_high, addr_low, port_number, transport_code,
                                          // is_ipv6, black_ttl, gray_ttl, allow_white,
                                          // allow_black, zero pad
  input  logic [KIND_W-1:0]     s_tuser,  // kind
  output logic                  q_valid,
  input  logic                  q_ready,
  output hbgt_item_t            q_item
);

  hbgt_in_word_t in_word;
  hbgt_op_t      op;
  hbgt_item_t    fifo_mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign in_word = hbgt_in_word_t'(s_tdata);

  always_comb begin
    unique case (s_tuser)
      KIND_BLACKLIST: op = OP_BLACKLIST;
      KIND_SELECT:    op = OP_SELECT;
      KIND_SUCCESS:   op = OP_SUCCESS;
      KIND_CLEAR:     op = OP_CLEAR;
      KIND_TICK:      op = OP_TICK;
      default:        op = OP_NONE;
    endcase
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = fifo_mem[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{op:          op,
                            key:         in_word.key,
                            black_ttl:   in_word.black_ttl,
                            gray_ttl:    in_word.gray_ttl,
                            allow_white: in_word.allow_white,
                            allow_black: in_word.allow_black};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/hbgt_back.sv @@
module hbgt_back import hbgt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  hbgt_item_t             q_item,
  output hbgt_back_status_t      bstat,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // host_status, allowed, table_full, zero pad
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                   state;
  hbgt_item_t               item;
  logic [31:0]              now_sec;
  logic [TABLE_ENTRIES-1:0] valid;
  hbgt_entry_t              mem [TABLE_ENTRIES];
  hbgt_entry_t              rdata;
  logic [CNT_W-1:0]         cnt;
  logic                     rd_pend;
  logic [IDX_W-1:0]         rd_idx;
  logic                     rd_en;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  hbgt_entry_t              hit_entry;
  logic                     hit_black;
  logic                     hit_gray;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [31:0]              black_new;
  hbgt_out_word_t           res;
  hbgt_out_word_t           res_next;
  hbgt_out_word_t           out_word;
  logic                     out_valid;
  logic                     out_load;

  logic [32:0]      black_sum;
  logic [32:0]      gray_sum;
  logic [31:0]      gray_new;
  logic [32:0]      tick_sum;
  logic             entry_hit;
  logic [1:0]       sel_status;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  hbgt_entry_t      wr_data;
  logic             v_set;
  logic             v_clr;

  assign black_sum = {1'b0, now_sec} + {13'b0, q_item.black_ttl};
  assign gray_sum  = {1'b0, black_new} + {13'b0, item.gray_ttl};
  assign gray_new  = gray_sum[32] ? '1 : gray_sum[31:0];
  assign tick_sum  = {1'b0, now_sec} + 33'd1;

  assign rd_en     = (state == S_SCAN) && (cnt != LAST_CNT);
  assign entry_hit = rd_pend && valid[rd_idx] && (rdata.key == item.key);
  assign out_load  = (state == S_DONE) && (!out_valid || m_tready);

  always_comb begin
    if (!hit) begin
      sel_status = ST_WHITE;
    end else if (hit_black) begin
      sel_status = ST_BLACK;
    end else if (hit_gray) begin
      sel_status = hit_entry.probing_mark ? ST_GRAY_PROBE : ST_GRAY_IDLE;
    end else begin
      sel_status = ST_WHITE;
    end
  end

  always_comb begin
    res_next = '0;
    wr_en    = 1'b0;
    wr_idx   = hit_idx;
    wr_data  = hit_entry;
    v_set    = 1'b0;
    v_clr    = 1'b0;
    case (item.op)
      OP_BLACKLIST: begin
        wr_idx = hit ? hit_idx : free_idx;
        wr_data = '{key:          item.key,
                    black_expiry: black_new,
                    gray_expiry:  gray_new,
                    probing_mark: 1'b0};
        if (hit || free_found) begin
          wr_en = 1'b1;
          v_set = 1'b1;
        end else begin
          res_next.table_full = 1'b1;
        end
      end
      OP_SELECT: begin
        res_next.host_status = sel_status;
        if (sel_status == ST_WHITE || sel_status == ST_GRAY_IDLE) begin
          res_next.allowed = item.allow_white;
        end else begin
          res_next.allowed = item.allow_black;
        end
        v_clr = hit && (sel_status == ST_WHITE);
        if (sel_status == ST_GRAY_IDLE && item.allow_white) begin
          wr_en = 1'b1;
          wr_data.probing_mark = 1'b1;
        end
      end
      OP_SUCCESS: begin
        if (hit && !hit_black) begin
          wr_en = 1'b1;
          wr_data.black_expiry = '0;
          wr_data.gray_expiry  = '0;
          wr_data.probing_mark = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      now_sec    <= '0;
      out_valid  <= 1'b0;
      cnt        <= '0;
      rd_pend    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            item       <= q_item;
            black_new  <= black_sum[32] ? '1 : black_sum[31:0];
            hit        <= 1'b0;
            free_found <= 1'b0;
            cnt        <= '0;
            rd_pend    <= 1'b0;
            res        <= '0;
            case (q_item.op) inside
              OP_BLACKLIST, OP_SELECT, OP_SUCCESS: state <= S_SCAN;
              OP_CLEAR: begin
                valid <= '0;
                state <= S_DONE;
              end
              OP_TICK: begin
                now_sec <= tick_sum[32] ? '1 : tick_sum[31:0];
                state   <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          rd_pend <= rd_en;
          rd_idx  <= cnt[IDX_W-1:0];
          if (rd_en) begin
            cnt <= cnt + 1'b1;
          end
          if (entry_hit) begin
            hit       <= 1'b1;
            hit_idx   <= rd_idx;
            hit_entry <= rdata;
            hit_black <= now_sec < rdata.black_expiry;
            hit_gray  <= now_sec < rdata.gray_expiry;
            state     <= S_EXEC;
          end else begin
            if (rd_pend && !valid[rd_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (!rd_pend && cnt == LAST_CNT) begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          res <= res_next;
          if (v_set) begin
            valid[wr_idx] <= 1'b1;
          end
          if (v_clr) begin
            valid[hit_idx] <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= res;
    end
  end

  assign q_ready              = (state == S_IDLE);
  assign m_tvalid             = out_valid;
  assign m_tdata              = out_word;
  assign bstat.busy           = (state != S_IDLE);
  assign bstat.result_pending = out_valid;

endmodule

@@ src/host_blacklist_graylist_table.sv @@
// Unhealthy host table: up to TABLE_ENTRIES records keyed by address, port, transport and
// family, each black until its black expiry, then gray (probing or not) until its gray
// expiry, then white. Every input word gives exactly one result word. Words enter a
// two-deep queue; the table engine behind it takes one at a time. Blacklist, select and
// success scan the record memory one entry a cycle through its single read port, stopping
// early when the host is found; tick, clear and unused kinds skip the scan. The table is
// empty after reset with no clearing pass.
`include "assert_macros.svh"

module host_blacklist_graylist_table import hbgt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // addr_high, addr_low, port_number,
                                            // transport_code, is_ipv6, black_ttl,
                                            // gray_ttl, allow_white, allow_black, zero pad
  input  logic [KIND_W-1:0]      s_tuser,   // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // host_status, allowed, table_full, zero pad
);

  logic              q_valid;
  logic              q_ready;
  hbgt_item_t        q_item;
  hbgt_back_status_t bstat;

  hbgt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  hbgt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .bstat    (bstat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `ASSERT_PROP(a_pop_starts_work, (q_valid && q_ready) |=> bstat.busy, "pop without work")
  `ASSERT_PROP(a_idle_takes_work, !bstat.busy |-> q_ready, "idle engine not ready")
  `ASSERT_NEVER(a_full_with_status, m_tvalid && m_tdata[3] && m_tdata[1:0] != ST_WHITE, "full on select")
  `ASSERT_NEVER(a_full_allowed, bstat.result_pending && m_tdata[3] && m_tdata[2], "full and allowed")

endmodule

@@ sim/host_blacklist_graylist_table_tb.sv @@
`timescale 1ns / 100ps

module host_blacklist_graylist_table_tb;
  import hbgt_pkg::*;

  localparam int HOST_SLOTS = 16;
  localparam int POOL_SIZE = 24;
  localparam int RANDOM_WORDS = 1450;
  localparam int LONG_HOLD_AT = 400;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_LAST = 3'd7;

  typedef struct {
    logic [KIND_W-1:0] kind;
    hbgt_key_t         key;
    logic [19:0]       black_ttl;
    logic [19:0]       gray_ttl;
    logic              allow_white;
    logic              allow_black;
    bit                drain_first;
  } host_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  host_blacklist_graylist_table #(
    .TABLE_ENTRIES(HOST_SLOTS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("host_blacklist_graylist_table_tb: FAIL");
    $finish;
  end

  // shadow host table
  logic        rec_valid [HOST_SLOTS];
  hbgt_key_t   rec_key   [HOST_SLOTS];
  logic [31:0] rec_black [HOST_SLOTS];
  logic [31:0] rec_gray  [HOST_SLOTS];
  logic        rec_probe [HOST_SLOTS];
  logic [31:0] now_sec = '0;

  host_req_t      queued_requests[$];
  hbgt_out_word_t due_verdicts[$];
  hbgt_key_t      key_pool[POOL_SIZE];

  host_req_t      on_bus;
  hbgt_in_word_t  bus_word;
  hbgt_out_word_t got_word;
  hbgt_out_word_t want_word;
  bit  word_taken = 0;
  bit  drain_next = 0;
  int  req_count = 0;
  int  cycle_no = 0;
  int  errors = 0;
  int  results_seen = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  int  kind_seen[8];
  int  status_seen[4];
  int  full_seen = 0;
  wire quiet = (cycle_no >= 9000) && (cycle_no < 13000);

  initial begin
    for (int i = 0; i < HOST_SLOTS; i++) rec_valid[i] = 1'b0;
    for (int i = 0; i < 8; i++) kind_seen[i] = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
  end

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int find_host(hbgt_key_t k);
    for (int i = 0; i < HOST_SLOTS; i++) begin
      if (rec_valid[i] && rec_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic logic [1:0] rec_status(int i);
    if (now_sec < rec_black[i]) return ST_BLACK;
    if (now_sec < rec_gray[i]) return rec_probe[i] ? ST_GRAY_PROBE : ST_GRAY_IDLE;
    return ST_WHITE;
  endfunction

  // applies one word to the shadow table and returns the answer it must produce
  function automatic hbgt_out_word_t host_verdict(host_req_t q);
    hbgt_out_word_t v;
    int hit;
    v = '0;
    hit = find_host(q.key);
    case (q.kind)
      KIND_BLACKLIST: begin
        if (hit < 0) begin
          for (int f = HOST_SLOTS - 1; f >= 0; f--) begin
            if (!rec_valid[f]) hit = f;
          end
        end
        if (hit < 0) begin
          v.table_full = 1'b1;
        end else begin
          rec_valid[hit] = 1'b1;
          rec_key[hit] = q.key;
          rec_black[hit] = add_sat(now_sec, {12'd0, q.black_ttl});
          rec_gray[hit] = add_sat(rec_black[hit], {12'd0, q.gray_ttl});
          rec_probe[hit] = 1'b0;
        end
      end
      KIND_SELECT: begin
        if (hit >= 0) begin
          v.host_status = rec_status(hit);
          if (v.host_status == ST_WHITE) rec_valid[hit] = 1'b0;
        end
        v.allowed = (v.host_status == ST_WHITE || v.host_status == ST_GRAY_IDLE) ?
                    q.allow_white : q.allow_black;
        if (v.host_status == ST_GRAY_IDLE && q.allow_white) rec_probe[hit] = 1'b1;
      end
      KIND_SUCCESS: begin
        if (hit >= 0 && rec_status(hit) != ST_BLACK) begin
          rec_probe[hit] = 1'b0;
          rec_black[hit] = '0;
          rec_gray[hit] = '0;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < HOST_SLOTS; i++) rec_valid[i] = 1'b0;
      end
      KIND_TICK: begin
        now_sec = add_sat(now_sec, 32'd1);
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  function automatic hbgt_key_t rand_key();
    hbgt_key_t k;
    k.addr_high = {$urandom, $urandom};
    k.addr_low = {$urandom, $urandom};
    k.port_number = 16'($urandom);
    k.transport_code = 8'($urandom);
    k.is_ipv6 = 1'($urandom);
    if (!k.is_ipv6 && $urandom_range(3) != 0) begin
      k.addr_high = '0;
      k.addr_low[63:32] = '0;
    end
    return k;
  endfunction

  function automatic hbgt_key_t pick_key();
    if ($urandom_range(99) < 90) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return rand_key();
  endfunction

  function automatic logic [19:0] ttl_draw();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 20'($urandom_range(8));
    if (r < 95) return 20'($urandom_range(40));
    return 20'($urandom);
  endfunction

  task automatic queue_req(logic [KIND_W-1:0] kind, hbgt_key_t key, logic [19:0] bttl,
                           logic [19:0] gttl, logic aw, logic ab);
    host_req_t q;
    q.kind = kind;
    q.key = key;
    q.black_ttl = bttl;
    q.gray_ttl = gttl;
    q.allow_white = aw;
    q.allow_black = ab;
    q.drain_first = drain_next;
    drain_next = 0;
    queued_requests = {queued_requests, q};
    req_count++;
  endtask

  task automatic queue_random(logic [KIND_W-1:0] kind, hbgt_key_t key);
    queue_req(kind, key, ttl_draw(), ttl_draw(), 1'($urandom), 1'($urandom));
  endtask

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // input side: accept and predict
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      due_verdicts = {due_verdicts, host_verdict(on_bus)};
      kind_seen[on_bus.kind]++;
      word_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || word_taken)) begin
      word_taken = 0;
      if (queued_requests.size() == 0 || (!quiet && $urandom_range(99) < 8) ||
          (queued_requests[0].drain_first && due_verdicts.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        on_bus = queued_requests.pop_front();
        bus_word = '0;
        bus_word.key = on_bus.key;
        bus_word.black_ttl = on_bus.black_ttl;
        bus_word.gray_ttl = on_bus.gray_ttl;
        bus_word.allow_white = on_bus.allow_white;
        bus_word.allow_black = on_bus.allow_black;
        s_tvalid <= 1'b1;
        s_tdata <= bus_word;
        s_tuser <= on_bus.kind;
      end
    end
  end

  // output side: backpressure, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= LONG_HOLD_AT) begin
      hold_done = 1;
      hold_left = LONG_HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_word = m_tdata;
      results_seen++;
      if (due_verdicts.size() == 0) begin
        $display("%0t: unexpected result word, got status %0d allowed %0d full %0d",
                 $time, got_word.host_status, got_word.allowed, got_word.table_full);
        errors++;
      end else begin
        want_word = due_verdicts.pop_front();
        status_seen[want_word.host_status]++;
        if (want_word.table_full) full_seen++;
        if (got_word.host_status !== want_word.host_status ||
            got_word.allowed !== want_word.allowed ||
            got_word.table_full !== want_word.table_full) begin
          $display("%0t: mismatch, expected status %0d allowed %0d full %0d, got %0d %0d %0d",
                   $time, want_word.host_status, want_word.allowed, want_word.table_full,
                   got_word.host_status, got_word.allowed, got_word.table_full);
          errors++;
        end
      end
    end
  end

  initial begin
    hbgt_key_t ones;
    hbgt_key_t k;
    int start_idx;
    int steps;
    int r;
    int random_base;
    bit mid_drained;

    mid_drained = 0;
    ones = '1;
    key_pool[0] = rand_key();
    key_pool[0].is_ipv6 = 1'b1;
    for (int i = 1; i < POOL_SIZE; i++) key_pool[i] = rand_key();
    // near neighbors of the first host, one key field apart
    key_pool[1] = key_pool[0];
    key_pool[1].port_number[0] = ~key_pool[0].port_number[0];
    key_pool[2] = key_pool[0];
    key_pool[2].is_ipv6 = 1'b0;
    key_pool[3] = key_pool[0];
    key_pool[3].transport_code[7] = ~key_pool[0].transport_code[7];
    key_pool[4] = key_pool[0];
    key_pool[4].addr_high[63] = ~key_pool[0].addr_high[63];
    key_pool[5] = key_pool[0];
    key_pool[5].addr_low[0] = ~key_pool[0].addr_low[0];

    // directed
    queue_req(KIND_SELECT, key_pool[0], '0, '0, 1'b1, 1'b0);
    queue_req(KIND_SELECT, ones, '0, '0, 1'b0, 1'b1);
    queue_req(KIND_BLACKLIST, key_pool[0], 20'd2, 20'd3, 1'b0, 1'b0);
    queue_req(KIND_SELECT, key_pool[0], '0, '0, 1'b1, 1'b0);
    queue_req(KIND_SELECT, key_pool[1], '0, '0, 1'b1, 1'b1);
    queue_req(KIND_SUCCESS, key_pool[0], '0, '0, 1'b0, 1'b0);
    queue_req(KIND_TICK, '0, '0, '0, 1'b0, 1'b0);
    queue_req(KIND_TICK, ones, '1, '1, 1'b1, 1'b1);
    queue_req(KIND_SELECT, key_pool[0], '0, '0, 1'b0, 1'b1);
    queue_req(KIND_SELECT, key_pool[0], '0, '0, 1'b1, 1'b0);
    queue_req(KIND_SELECT, key_pool[0], '0, '0, 1'b0, 1'b1);
    queue_req(KIND_SUCCESS, key_pool[0], '0, '0, 1'b0, 1'b0);
    queue_req(KIND_SELECT, key_pool[0], '0, '0, 1'b1, 1'b1);
    queue_req(KIND_BLACKLIST, ones, '1, '1, 1'b1, 1'b1);
    queue_req(KIND_SELECT, ones, '0, '0, 1'b1, 1'b1);
    queue_req(KIND_BLACKLIST, key_pool[2], '0, '0, 1'b0, 1'b0);
    queue_req(KIND_SELECT, key_pool[2], '0, '0, 1'b0, 1'b0);
    queue_req(KIND_BLACKLIST, key_pool[3], '0, 20'd5, 1'b0, 1'b0);
    queue_req(KIND_SELECT, key_pool[3], '0, '0, 1'b1, 1'b0);
    queue_req(KIND_BLACKLIST, key_pool[3], 20'd1, 20'd1, 1'b0, 1'b0);
    queue_req(KIND_SELECT, key_pool[3], '0, '0, 1'b0, 1'b1);
    for (int u = KIND_RSVD_FIRST; u <= KIND_RSVD_LAST; u++) begin
      queue_req(KIND_W'(u), ones, '1, '1, 1'b1, 1'b1);
    end
    queue_req(KIND_CLEAR, '0, '0, '0, 1'b0, 1'b0);
    queue_req(KIND_SELECT, ones, '0, '0, 1'b1, 1'b0);

    // random
    drain_next = 1;
    random_base = req_count;
    while (req_count - random_base < RANDOM_WORDS) begin
      r = $urandom_range(99);
      if (r < 3) begin
        // fill to capacity, rewrite a resident host, then overflow
        start_idx = $urandom_range(POOL_SIZE - 1);
        queue_req(KIND_CLEAR, pick_key(), '0, '0, 1'b0, 1'b0);
        for (int j = 0; j < HOST_SLOTS; j++) begin
          queue_random(KIND_BLACKLIST, key_pool[(start_idx + j) % POOL_SIZE]);
        end
        queue_random(KIND_BLACKLIST, key_pool[start_idx]);
        queue_random(KIND_BLACKLIST, rand_key());
        queue_random(KIND_SELECT, key_pool[start_idx]);
      end else if (r < 45) begin
        // one host walked through black, gray and white
        k = pick_key();
        queue_req(KIND_BLACKLIST, k, 20'($urandom_range(4)), 20'($urandom_range(6)),
                  1'($urandom), 1'($urandom));
        steps = $urandom_range(10, 3);
        for (int j = 0; j < steps; j++) begin
          r = $urandom_range(99);
          if (r < 40) queue_random(KIND_TICK, pick_key());
          else if (r < 80) queue_random(KIND_SELECT, k);
          else if (r < 95) queue_random(KIND_SUCCESS, k);
          else queue_req(KIND_BLACKLIST, k, 20'($urandom_range(3)), 20'($urandom_range(5)),
                         1'($urandom), 1'($urandom));
        end
      end else begin
        r = $urandom_range(999);
        if (r < 250) queue_random(KIND_BLACKLIST, pick_key());
        else if (r < 650) queue_random(KIND_SELECT, pick_key());
        else if (r < 770) queue_random(KIND_SUCCESS, pick_key());
        else if (r < 970) queue_random(KIND_TICK, pick_key());
        else if (r < 977) queue_random(KIND_CLEAR, pick_key());
        else if (r < 990) queue_random(KIND_W'($urandom_range(KIND_RSVD_LAST, KIND_RSVD_FIRST)),
                                       pick_key());
        else queue_random(KIND_SELECT, rand_key());
      end
      if (!mid_drained && req_count - random_base > 800) begin
        mid_drained = 1;
        drain_next = 1;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (queued_requests.size() != 0 || s_tvalid || due_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("covered %0d blacklist (%0d dropped on a full table), %0d select, %0d success,",
             kind_seen[KIND_BLACKLIST], full_seen, kind_seen[KIND_SELECT],
             kind_seen[KIND_SUCCESS]);
    $display("  %0d clear, %0d tick, %0d unused, answers w/g/p/b %0d/%0d/%0d/%0d, %0d checked",
             kind_seen[KIND_CLEAR], kind_seen[KIND_TICK],
             kind_seen[5] + kind_seen[6] + kind_seen[7], status_seen[ST_WHITE],
             status_seen[ST_GRAY_IDLE], status_seen[ST_GRAY_PROBE], status_seen[ST_BLACK],
             results_seen);
    if (errors == 0) begin
      $display("host_blacklist_graylist_table_tb: PASS");
    end else begin
      $display("host_blacklist_graylist_table_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/hbgt_pkg.sv
src/hbgt_front.sv
src/hbgt_back.sv
src/host_blacklist_graylist_table.sv
sim/host_blacklist_graylist_table_tb.sv
